// ===== hw/rtl/lcd_text_framebuffer_renderer_macros.svh =====
// assertion macros used by the checker file
`ifndef LCD_TEXT_FRAMEBUFFER_RENDERER_MACROS_SVH
`define LCD_TEXT_FRAMEBUFFER_RENDERER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LTFR_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LTFR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/lcdtfr_pkg.sv =====
`default_nettype none
package lcdtfr_pkg;

  // operation codes of an input request
  localparam logic [2:0] OP_LOAD_FONT = 3'd0;
  localparam logic [2:0] OP_PLACE     = 3'd1;
  localparam logic [2:0] OP_END_LINE  = 3'd2;
  localparam logic [2:0] OP_REFRESH   = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;

  // glyph layout
  localparam int GLYPH_BYTES = 25;
  localparam int GLYPH_COLS  = 12;
  localparam int FIRST_CODE  = 32;
  localparam int STEP_W      = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(GLYPH_BYTES - 1);

  // display command bytes
  localparam logic [7:0] CMD_COL_LO = 8'h00;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] CMD_PAGE   = 8'hB0;

  // controller to datapath commands
  typedef struct packed {
    logic              font_wr;
    logic              place_rd;
    logic [STEP_W-1:0] step;
    logic              end_line;
    logic              refresh;
    logic              out_load;
    logic              clr_wr;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic place_ok;
    logic out_free;
    logic clr_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lcd_text_framebuffer_renderer.sv =====
`default_nettype none
// channel   direction  handshake           payload
// in_       input      in_valid/in_stall   operation, font_address, font_byte, character, line
// out_      output     out_valid/out_stall lcd_byte, is_data, last
//
// font load, end line, ignored codes and rejected characters complete in the cycle they are accepted
// a placed glyph makes 25 font store reads, one per cycle, plus one write tail
// a refresh step is a frame buffer read, then an output register load once that register is free
// after reset and on clear, a sweep writes zeros over all 4*PAGE_WIDTH frame buffer bytes, in_stall high
// requests keep flowing while a result waits; only a refresh waits for a free output register
module lcd_text_framebuffer_renderer #(
  parameter int GLYPH_COUNT = 96,
  parameter int PAGE_WIDTH  = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_operation,
  input  wire logic [11:0] in_font_address,
  input  wire logic [7:0]  in_font_byte,
  input  wire logic [7:0]  in_character,
  input  wire logic        in_line,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_lcd_byte,
  output logic             out_is_data,
  output logic             out_last
);

  lcdtfr_pkg::cmd_t cmd;
  lcdtfr_pkg::sts_t sts;

  // sequencer
  lcdtfr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .sts          (sts),
    .in_stall     (in_stall),
    .cmd          (cmd)
  );

  // memories, columns, stream counters and output register
  lcdtfr_datapath #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .PAGE_WIDTH  (PAGE_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_font_address (in_font_address),
    .in_font_byte    (in_font_byte),
    .in_character    (in_character),
    .in_line         (in_line),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_lcd_byte    (out_lcd_byte),
    .out_is_data     (out_is_data),
    .out_last        (out_last),
    .sts             (sts)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/lcdtfr_ctrl.sv =====
`default_nettype none
module lcdtfr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [2:0]        in_operation,
  input  wire lcdtfr_pkg::sts_t  sts,
  output logic                   in_stall,
  output lcdtfr_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLACE,
    ST_TAIL,
    ST_REFRESH
  } state_t;

  state_t                          state_r, state_nxt;
  logic [lcdtfr_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                            accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_operation)
            lcdtfr_pkg::OP_LOAD_FONT: cmd.font_wr = 1'b1;
            lcdtfr_pkg::OP_PLACE: begin
              if (sts.place_ok) begin
                cmd.place_rd = 1'b1;
                cmd.step     = '0;
                step_nxt     = lcdtfr_pkg::STEP_W'(1);
                state_nxt    = ST_PLACE;
              end
            end
            lcdtfr_pkg::OP_END_LINE: cmd.end_line = 1'b1;
            lcdtfr_pkg::OP_REFRESH: begin
              cmd.refresh = 1'b1;
              state_nxt   = ST_REFRESH;
            end
            lcdtfr_pkg::OP_CLEAR: state_nxt = ST_CLEAR;
            default: ;
          endcase
        end
      end
      ST_PLACE: begin
        cmd.place_rd = 1'b1;
        cmd.step     = step_r;
        if (step_r == lcdtfr_pkg::LAST_STEP) begin
          state_nxt = ST_TAIL;
        end else begin
          step_nxt = step_r + lcdtfr_pkg::STEP_W'(1);
        end
      end
      ST_TAIL: state_nxt = ST_IDLE;
      ST_REFRESH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lcdtfr_datapath.sv =====
`default_nettype none
module lcdtfr_datapath #(
  parameter int GLYPH_COUNT = 96,
  parameter int PAGE_WIDTH  = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lcdtfr_pkg::cmd_t  cmd,
  input  wire logic [11:0]       in_font_address,
  input  wire logic [7:0]        in_font_byte,
  input  wire logic [7:0]        in_character,
  input  wire logic              in_line,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic [7:0]             out_lcd_byte,
  output logic                   out_is_data,
  output logic                   out_last,
  output lcdtfr_pkg::sts_t       sts
);

  localparam int FONT_DEPTH = lcdtfr_pkg::GLYPH_BYTES * GLYPH_COUNT;
  localparam int FA_W       = $clog2(FONT_DEPTH);
  localparam int FB_DEPTH   = 4 * PAGE_WIDTH;
  localparam int FB_AW      = $clog2(FB_DEPTH);
  localparam int COL_W      = $clog2(PAGE_WIDTH);
  localparam int PAGE_SPAN  = PAGE_WIDTH + 3;
  localparam int PS_W       = $clog2(PAGE_SPAN);
  localparam int SW         = lcdtfr_pkg::STEP_W;

  // memories
  logic [7:0] font_mem [FONT_DEPTH];
  logic [7:0] fb_mem   [FB_DEPTH];
  logic [7:0] font_q_r;
  logic [7:0] fb_q_r;

  // column and glyph context
  logic [COL_W-1:0] top_col_r, bot_col_r;
  logic [COL_W-1:0] col_r;
  logic             line_r;
  logic [FA_W-1:0]  off_r;
  logic             rd_pend_r;
  logic [SW-1:0]    step_d_r;

  // stream and sweep counters
  logic [1:0]       page_r;
  logic [PS_W-1:0]  pos_r;
  logic [FB_AW-1:0] clr_addr_r;

  // pending result and output register
  logic [7:0] res_byte_r;
  logic       res_data_r;
  logic       res_last_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_data_r;
  logic       out_last_r;

  // place acceptance check
  logic [COL_W-1:0] col_now;
  logic [COL_W:0]   fit_sum;
  logic [8:0]       code9;
  logic             code_ok;
  logic [7:0]       gidx;
  logic [FA_W-1:0]  off_now;
  logic [FA_W-1:0]  font_rd_addr;

  assign col_now = in_line ? bot_col_r : top_col_r;
  assign fit_sum = (COL_W+1)'(col_now) + (COL_W+1)'(lcdtfr_pkg::GLYPH_COLS);
  assign code9   = {1'b0, in_character};
  assign code_ok = (code9 >= 9'(lcdtfr_pkg::FIRST_CODE)) &&
                   (code9 < 9'(lcdtfr_pkg::FIRST_CODE + GLYPH_COUNT));
  assign gidx    = in_character - 8'(lcdtfr_pkg::FIRST_CODE);
  assign off_now = FA_W'(gidx) * FA_W'(lcdtfr_pkg::GLYPH_BYTES);
  assign font_rd_addr = (cmd.step == '0) ? off_now : off_r + FA_W'(cmd.step);

  assign sts.place_ok = code_ok && (fit_sum < (COL_W+1)'(PAGE_WIDTH - 1));
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.clr_last = (clr_addr_r == FB_AW'(FB_DEPTH - 1));

  // font store: load port and glyph read port
  logic font_addr_ok;
  assign font_addr_ok = {1'b0, in_font_address} < 13'(FONT_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.font_wr && font_addr_ok) begin
      font_mem[FA_W'(in_font_address)] <= in_font_byte;
    end
    if (cmd.place_rd) begin
      font_q_r <= font_mem[font_rd_addr];
    end
  end

  // glyph write address from the delayed step
  logic [3:0]       gcol;
  logic             lower;
  logic [FB_AW-1:0] glyph_addr;
  logic [8:0]       adv_sum;
  logic [COL_W-1:0] adv_col;

  assign gcol  = 4'((step_d_r - SW'(1)) >> 1);
  assign lower = !step_d_r[0];
  assign glyph_addr = (line_r ? FB_AW'(2 * PAGE_WIDTH) : FB_AW'(0)) + FB_AW'(col_r) +
                      FB_AW'(gcol) + (lower ? FB_AW'(PAGE_WIDTH) : FB_AW'(0));
  assign adv_sum = 9'(col_r) + 9'(font_q_r);
  assign adv_col = (adv_sum > 9'(PAGE_WIDTH - 1)) ? COL_W'(PAGE_WIDTH - 1)
                                                  : COL_W'(adv_sum);

  // frame buffer: one write port, one read port
  logic             fb_we;
  logic [FB_AW-1:0] fb_wa;
  logic [7:0]       fb_wd;
  logic [FB_AW-1:0] fb_ra;

  assign fb_we = cmd.clr_wr || (rd_pend_r && (step_d_r != '0));
  assign fb_wa = cmd.clr_wr ? clr_addr_r : glyph_addr;
  assign fb_wd = cmd.clr_wr ? 8'h00 : font_q_r;
  assign fb_ra = FB_AW'(page_r) * FB_AW'(PAGE_WIDTH) + FB_AW'(pos_r - PS_W'(3));

  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb_mem[fb_wa] <= fb_wd;
    end
    if (cmd.refresh) begin
      fb_q_r <= fb_mem[fb_ra];
    end
  end

  // glyph context latched at the first font read
  always_ff @(posedge clk) begin
    if (cmd.place_rd && (cmd.step == '0)) begin
      off_r  <= off_now;
      col_r  <= col_now;
      line_r <= in_line;
    end
    step_d_r <= cmd.step;
  end

  // columns, read pipeline flag and sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_col_r  <= '0;
      bot_col_r  <= '0;
      rd_pend_r  <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      rd_pend_r <= cmd.place_rd;
      if (cmd.end_line) begin
        top_col_r <= '0;
        bot_col_r <= '0;
      end else if (rd_pend_r && (step_d_r == '0)) begin
        if (line_r) begin
          bot_col_r <= adv_col;
        end else begin
          top_col_r <= adv_col;
        end
      end
      if (cmd.clr_wr) begin
        clr_addr_r <= sts.clr_last ? '0 : clr_addr_r + FB_AW'(1);
      end
    end
  end

  // stream position
  logic pos_end;
  assign pos_end = (pos_r == PS_W'(PAGE_SPAN - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r <= '0;
      pos_r  <= '0;
    end else if (cmd.refresh) begin
      if (pos_end) begin
        pos_r  <= '0;
        page_r <= page_r + 2'd1;
      end else begin
        pos_r <= pos_r + PS_W'(1);
      end
    end
  end

  // refresh byte selection
  always_ff @(posedge clk) begin
    if (cmd.refresh) begin
      res_data_r <= (pos_r > PS_W'(2));
      res_last_r <= pos_end && (page_r == 2'd3);
      if (pos_r == PS_W'(0)) begin
        res_byte_r <= lcdtfr_pkg::CMD_COL_LO;
      end else if (pos_r == PS_W'(1)) begin
        res_byte_r <= lcdtfr_pkg::CMD_COL_HI;
      end else if (pos_r == PS_W'(2)) begin
        res_byte_r <= lcdtfr_pkg::CMD_PAGE + {6'b0, page_r};
      end else begin
        res_byte_r <= 8'h00;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte_r <= res_data_r ? fb_q_r : res_byte_r;
      out_data_r <= res_data_r;
      out_last_r <= res_last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_lcd_byte = out_byte_r;
  assign out_is_data  = out_data_r;
  assign out_last     = out_last_r;

endmodule
`default_nettype wire

// ===== hw/rtl/lcdtfr_checker.sv =====
`default_nettype none
`include "lcd_text_framebuffer_renderer_macros.svh"
module lcdtfr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [2:0]  in_operation,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_lcd_byte,
  input wire logic        out_is_data,
  input wire logic        out_last
);

  logic [9:0] out_word;
  logic       cmd_byte_ok;
  logic       refresh_take;

  // result fields as one word
  assign out_word = {out_lcd_byte, out_is_data, out_last};

  // command bytes are column low, column high or a page select
  assign cmd_byte_ok = (out_lcd_byte == lcdtfr_pkg::CMD_COL_LO) ||
                       (out_lcd_byte == lcdtfr_pkg::CMD_COL_HI) ||
                       (out_lcd_byte[7:2] == lcdtfr_pkg::CMD_PAGE[7:2]);

  // refresh request taken
  assign refresh_take = in_valid && !in_stall && (in_operation == lcdtfr_pkg::OP_REFRESH);

  // a stalled result holds
  `LTFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled result changed")

  // the stream ends on a pixel byte
  `LTFR_ASSERT_NOW(a_last_is_data, out_valid && out_last, out_is_data, "last marked on a command byte")

  // only known command bytes
  `LTFR_ASSERT_NOW(a_cmd_byte, out_valid && !out_is_data, cmd_byte_ok, "bad command byte")

  // a refresh request holds off the next request while its byte is fetched
  `LTFR_ASSERT_NEXT(a_refresh_busy, refresh_take, in_stall, "request taken during refresh fetch")

endmodule

bind lcd_text_framebuffer_renderer lcdtfr_checker u_lcdtfr_checker (.*);
`default_nettype wire
